// File: src/slci_pkg.sv
package slci_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Restoring divider: one quotient bit per cell.
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // Square root: the radicand r*r - u*u stays below 2^62.
  localparam int SQ_IN_W   = 62;
  localparam int SQ_STEPS  = SQ_IN_W / 2;
  localparam int SQ_REM_W  = SQ_STEPS + 2;

  typedef enum logic [1:0] {
    CMD_SEG    = 2'd0,
    CMD_NEAR   = 2'd1,
    CMD_CIRCLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic               circ;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] dax;
    logic signed [31:0] day;
    logic [61:0]        rsq;
  } sb_div_t;

  typedef struct packed {
    logic               found;
    logic               circ;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] dax;
    logic signed [31:0] day;
    logic signed [31:0] t;
  } sb_sq_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// File: src/slci_div_cell.sv
module slci_div_cell #(
  parameter int REM_W = 66,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [Q_W-1:0]   low_i,
  input  logic [Q_W-1:0]   q_i,
  input  logic [REM_W-1:0] den_i,
  input  logic             neg_i,
  input  logic             ovf_i,
  output logic             vld_o,
  output logic [REM_W-1:0] rem_o,
  output logic [Q_W-1:0]   low_o,
  output logic [Q_W-1:0]   q_o,
  output logic [REM_W-1:0] den_o,
  output logic             neg_o,
  output logic             ovf_o
);

  logic [REM_W:0] remsh;
  logic [REM_W:0] diff;
  logic           take;

  always_comb begin
    remsh = {rem_i, low_i[Q_W-1]};
    diff  = remsh - {1'b0, den_i};
    take  = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_o <= take ? diff[REM_W-1:0] : remsh[REM_W-1:0];
    low_o <= {low_i[Q_W-2:0], 1'b0};
    q_o   <= {q_i[Q_W-2:0], take};
    den_o <= den_i;
    neg_o <= neg_i;
    ovf_o <= ovf_i;
  end

endmodule

// File: src/slci_div.sv
module slci_div #(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W     = 67,
  parameter int DEN_W     = 66
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output logic                    vld_o,
  output logic signed [31:0]      quo_o
);
  import slci_pkg::*;

  localparam int N_W   = NUM_W + FRAC_BITS;
  localparam int HI_W  = N_W - DIV_STEPS;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [N_W-1:0]   nsh;
  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] den_ext;

  logic                 vld_c [0:DIV_STEPS];
  logic [DEN_W-1:0]     rem_c [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] low_c [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] q_c   [0:DIV_STEPS];
  logic [DEN_W-1:0]     den_c [0:DIV_STEPS];
  logic                 neg_c [0:DIV_STEPS];
  logic                 ovf_c [0:DIV_STEPS];

  logic [DIV_STEPS-1:0] q_fin;
  logic                 big;

  always_comb begin
    num_mag = num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
    den_mag = den_i[DEN_W-1] ? (~den_i + 1'b1) : den_i;
    nsh     = {num_mag, {FRAC_BITS{1'b0}}};
    hi_ext  = CMP_W'(nsh[N_W-1:DIV_STEPS]);
    den_ext = CMP_W'(den_mag);
  end

  // The quotient fits in 32 bits only when the upper part of the numerator is below the
  // divisor; that part then seeds the remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c[0] <= 1'b0;
    end else begin
      vld_c[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_c[0] <= hi_ext[DEN_W-1:0];
    low_c[0] <= nsh[DIV_STEPS-1:0];
    q_c[0]   <= '0;
    den_c[0] <= den_mag;
    neg_c[0] <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    ovf_c[0] <= (hi_ext >= den_ext);
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    slci_div_cell #(
      .REM_W (DEN_W),
      .Q_W   (DIV_STEPS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_c[k]),
      .rem_i (rem_c[k]),
      .low_i (low_c[k]),
      .q_i   (q_c[k]),
      .den_i (den_c[k]),
      .neg_i (neg_c[k]),
      .ovf_i (ovf_c[k]),
      .vld_o (vld_c[k+1]),
      .rem_o (rem_c[k+1]),
      .low_o (low_c[k+1]),
      .q_o   (q_c[k+1]),
      .den_o (den_c[k+1]),
      .neg_o (neg_c[k+1]),
      .ovf_o (ovf_c[k+1])
    );
  end

  always_comb begin
    q_fin = q_c[DIV_STEPS];
    big   = ovf_c[DIV_STEPS] | q_fin[DIV_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_c[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (neg_c[DIV_STEPS]) begin
      quo_o <= big ? 32'sh8000_0000 : -$signed(q_fin);
    end else begin
      quo_o <= big ? 32'sh7FFF_FFFF : $signed(q_fin);
    end
  end

  property p_lat;
    @(posedge clk) disable iff (!rst_n) vld_i |-> ##(DIV_LAT) vld_o;
  endproperty
  a_lat: assert property (p_lat) else $error("divider word lost");

endmodule

// File: src/slci_sqrt_cell.sv
module slci_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [slci_pkg::SQ_REM_W-1:0] rem_i,
  input  logic [slci_pkg::SQ_IN_W-1:0]  val_i,
  input  logic [slci_pkg::SQ_STEPS-1:0] root_i,
  output logic                          vld_o,
  output logic [slci_pkg::SQ_REM_W-1:0] rem_o,
  output logic [slci_pkg::SQ_IN_W-1:0]  val_o,
  output logic [slci_pkg::SQ_STEPS-1:0] root_o
);
  import slci_pkg::*;

  logic [SQ_REM_W+1:0] remsh;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                take;

  always_comb begin
    remsh = {rem_i, val_i[SQ_IN_W-1 -: 2]};
    trial = (SQ_REM_W+2)'({root_i, 2'b01});
    diff  = remsh - trial;
    take  = (remsh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_o  <= take ? diff[SQ_REM_W-1:0] : remsh[SQ_REM_W-1:0];
    val_o  <= {val_i[SQ_IN_W-3:0], 2'b00};
    root_o <= {root_i[SQ_STEPS-2:0], take};
  end

endmodule

// File: src/slci_sqrt.sv
module slci_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [slci_pkg::SQ_IN_W-1:0]  val_i,
  output logic                          vld_o,
  output logic [slci_pkg::SQ_STEPS-1:0] root_o
);
  import slci_pkg::*;

  logic                vld_c  [0:SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_c  [0:SQ_STEPS];
  logic [SQ_IN_W-1:0]  val_c  [0:SQ_STEPS];
  logic [SQ_STEPS-1:0] root_c [0:SQ_STEPS];

  assign vld_c[0]  = vld_i;
  assign rem_c[0]  = '0;
  assign val_c[0]  = val_i;
  assign root_c[0] = '0;

  // Each cell brings down two radicand bits and settles one root bit.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_cell
    slci_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_c[k]),
      .rem_i  (rem_c[k]),
      .val_i  (val_c[k]),
      .root_i (root_c[k]),
      .vld_o  (vld_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .val_o  (val_c[k+1]),
      .root_o (root_c[k+1])
    );
  end

  assign vld_o  = vld_c[SQ_STEPS];
  assign root_o = root_c[SQ_STEPS];

endmodule

// File: src/segment_line_circle_intersect_unit.sv
// Channel  | Handshake      | Word
// ---------+----------------+-------------------------------------------------
// input    | start / busy   | in_command, segment, second object
// result   | out_valid      | out_found, out_hit_x, out_hit_y, out_hit_param
//
// One word is taken every cycle; busy stays low, nothing stalls the pipeline.
// Each result passes through stages 0 to 2, the divider with its 32 cells, stages U1 and U2,
// the square root with its 31 cells, and stages P, M and the output stage.
// Reset is synchronous and clears only the valid bits of the stages.
// The result is shown for a single cycle under out_valid; the receiver cannot stall.
module segment_line_circle_intersect_unit #(
  parameter int FRAC_BITS = slci_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_seg_start_x,
  input  logic signed [31:0] in_seg_start_y,
  input  logic signed [31:0] in_seg_dir_x,
  input  logic signed [31:0] in_seg_dir_y,
  input  logic [30:0]        in_seg_len,
  input  logic signed [31:0] in_other_x,
  input  logic signed [31:0] in_other_y,
  input  logic signed [31:0] in_other_dir_x,
  input  logic signed [31:0] in_other_dir_y,
  input  logic [30:0]        in_other_len_or_radius,
  output logic               out_valid,
  output logic               out_found,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_param
);
  import slci_pkg::*;

  localparam int NUM_W     = 67;
  localparam int DEN_W     = 66;
  localparam int TOTAL_LAT = 3 + DIV_LAT + 2 + SQ_STEPS + 3;

  assign busy = 1'b0;

  // Stage 0: register the word and form B - A.
  logic               s0_vld_r;
  cmd_t               s0_cmd_r;
  logic signed [31:0] s0_ax_r, s0_ay_r, s0_dax_r, s0_day_r, s0_dbx_r, s0_dby_r;
  logic signed [32:0] s0_ex_r, s0_ey_r;
  logic               s0_len_nz_r;
  logic [30:0]        s0_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_cmd_r    <= cmd_t'(in_command);
    s0_ax_r     <= in_seg_start_x;
    s0_ay_r     <= in_seg_start_y;
    s0_dax_r    <= in_seg_dir_x;
    s0_day_r    <= in_seg_dir_y;
    s0_dbx_r    <= in_other_dir_x;
    s0_dby_r    <= in_other_dir_y;
    s0_ex_r     <= {in_other_x[31], in_other_x} - {in_seg_start_x[31], in_seg_start_x};
    s0_ey_r     <= {in_other_y[31], in_other_y} - {in_seg_start_y[31], in_seg_start_y};
    s0_len_nz_r <= (in_seg_len != '0);
    s0_r_r      <= in_other_len_or_radius;
  end

  // Stage 1: products. The second direction is dB for two segments and the
  // perpendicular (-dA.y, dA.x) otherwise.
  logic signed [32:0] qx, qy, dax_e, day_e;
  logic               ok_pre;

  always_comb begin
    dax_e = {s0_dax_r[31], s0_dax_r};
    day_e = {s0_day_r[31], s0_day_r};
    if (s0_cmd_r == CMD_SEG) begin
      qx = {s0_dbx_r[31], s0_dbx_r};
      qy = {s0_dby_r[31], s0_dby_r};
    end else begin
      qx = -day_e;
      qy = dax_e;
    end
    unique case (s0_cmd_r)
      CMD_SEG:    ok_pre = s0_len_nz_r & (s0_r_r != '0);
      CMD_NEAR:   ok_pre = s0_len_nz_r;
      CMD_CIRCLE: ok_pre = s0_len_nz_r & (s0_r_r != '0);
      default:    ok_pre = 1'b0;
    endcase
  end

  logic               s1_vld_r;
  logic signed [65:0] s1_n1a_r, s1_n1b_r, s1_da_r, s1_db_r, s1_n2a_r, s1_n2b_r;
  sb_div_t            s1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_n1a_r     <= s0_ex_r * qy;
    s1_n1b_r     <= s0_ey_r * qx;
    s1_da_r      <= dax_e * qy;
    s1_db_r      <= day_e * qx;
    s1_n2a_r     <= s0_ex_r * day_e;
    s1_n2b_r     <= s0_ey_r * dax_e;
    s1_sb_r.ok   <= ok_pre;
    s1_sb_r.circ <= (s0_cmd_r == CMD_CIRCLE);
    s1_sb_r.ax   <= s0_ax_r;
    s1_sb_r.ay   <= s0_ay_r;
    s1_sb_r.dax  <= s0_dax_r;
    s1_sb_r.day  <= s0_day_r;
    s1_sb_r.rsq  <= s0_r_r * s0_r_r;
  end

  // Stage 2: cross products. The circle's u uses the negated denominator, so
  // its numerator is negated here and the same denominator is shared.
  logic                    s2_vld_r;
  logic signed [NUM_W-1:0] s2_num1_r, s2_num2_r;
  logic signed [DEN_W-1:0] s2_den_r;
  sb_div_t                 s2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_num1_r    <= {s1_n1a_r[65], s1_n1a_r} - {s1_n1b_r[65], s1_n1b_r};
    s2_num2_r    <= {s1_n2a_r[65], s1_n2a_r} - {s1_n2b_r[65], s1_n2b_r};
    s2_den_r     <= s1_da_r - s1_db_r;
    s2_sb_r.ok   <= s1_sb_r.ok & (s1_da_r != s1_db_r);
    s2_sb_r.circ <= s1_sb_r.circ;
    s2_sb_r.ax   <= s1_sb_r.ax;
    s2_sb_r.ay   <= s1_sb_r.ay;
    s2_sb_r.dax  <= s1_sb_r.dax;
    s2_sb_r.day  <= s1_sb_r.day;
    s2_sb_r.rsq  <= s1_sb_r.rsq;
  end

  // Two dividers side by side: t and u.
  logic               div_vld;
  logic               div_vld_u;
  logic signed [31:0] t_q, u_q;

  slci_div #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W),
    .DEN_W     (DEN_W)
  ) u_div_t (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s2_vld_r),
    .num_i (s2_num1_r),
    .den_i (s2_den_r),
    .vld_o (div_vld),
    .quo_o (t_q)
  );

  slci_div #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W),
    .DEN_W     (DEN_W)
  ) u_div_u (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s2_vld_r),
    .num_i (s2_num2_r),
    .den_i (s2_den_r),
    .vld_o (div_vld_u),
    .quo_o (u_q)
  );

  sb_div_t div_line_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    div_line_r[0] <= s2_sb_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      div_line_r[k] <= div_line_r[k-1];
    end
  end

  // Stage U1: u squared.
  logic               u1_vld_r;
  logic [62:0]        u1_usq_r;
  logic signed [31:0] u1_t_r;
  sb_div_t            u1_sb_r;
  logic signed [63:0] usq_full;

  assign usq_full = u_q * u_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_vld_r <= 1'b0;
    end else begin
      u1_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    u1_usq_r <= usq_full[62:0];
    u1_t_r   <= t_q;
    u1_sb_r  <= div_line_r[DIV_LAT-1];
  end

  // Stage U2: radicand and the circle-miss test.
  logic               u2_vld_r;
  logic [SQ_IN_W-1:0] u2_val_r;
  sb_sq_t             u2_sb_r;
  logic [63:0]        g2;

  assign g2 = {2'b00, u1_sb_r.rsq} - {1'b0, u1_usq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u2_vld_r <= 1'b0;
    end else begin
      u2_vld_r <= u1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    u2_val_r      <= g2[SQ_IN_W-1:0];
    u2_sb_r.found <= u1_sb_r.ok & ~(u1_sb_r.circ & g2[63]);
    u2_sb_r.circ  <= u1_sb_r.circ;
    u2_sb_r.ax    <= u1_sb_r.ax;
    u2_sb_r.ay    <= u1_sb_r.ay;
    u2_sb_r.dax   <= u1_sb_r.dax;
    u2_sb_r.day   <= u1_sb_r.day;
    u2_sb_r.t     <= u1_t_r;
  end

  logic                sq_vld;
  logic [SQ_STEPS-1:0] sq_root;

  slci_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (u2_vld_r),
    .val_i  (u2_val_r),
    .vld_o  (sq_vld),
    .root_o (sq_root)
  );

  sb_sq_t sq_line_r [0:SQ_STEPS-1];

  always_ff @(posedge clk) begin
    sq_line_r[0] <= u2_sb_r;
    for (int k = 1; k < SQ_STEPS; k++) begin
      sq_line_r[k] <= sq_line_r[k-1];
    end
  end

  // Stage P: final parameter.
  sb_sq_t             sq_sb;
  logic signed [63:0] t_minus;
  logic signed [31:0] param_nxt;

  always_comb begin
    sq_sb   = sq_line_r[SQ_STEPS-1];
    t_minus = 64'(sq_sb.t) - $signed({{(64-SQ_STEPS){1'b0}}, sq_root});
    if (!sq_sb.found) begin
      param_nxt = '0;
    end else if (sq_sb.circ) begin
      param_nxt = sat32(t_minus);
    end else begin
      param_nxt = sq_sb.t;
    end
  end

  logic               p_vld_r;
  sb_sq_t             p_sb_r;
  logic signed [31:0] p_param_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_sb_r    <= sq_sb;
    p_param_r <= param_nxt;
  end

  // Stage M: dA * param.
  logic               m_vld_r;
  logic               m_found_r;
  logic signed [31:0] m_ax_r, m_ay_r, m_param_r;
  logic signed [63:0] m_px_r, m_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_found_r <= p_sb_r.found;
    m_ax_r    <= p_sb_r.ax;
    m_ay_r    <= p_sb_r.ay;
    m_param_r <= p_param_r;
    m_px_r    <= p_sb_r.dax * p_param_r;
    m_py_r    <= p_sb_r.day * p_param_r;
  end

  // Output stage: floor by the fraction bits, add the start point, saturate.
  logic signed [63:0] hx_sum, hy_sum;

  always_comb begin
    hx_sum = 64'(m_ax_r) + (m_px_r >>> FRAC_BITS);
    hy_sum = 64'(m_ay_r) + (m_py_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_found     <= m_found_r;
    out_hit_x     <= m_found_r ? sat32(hx_sum) : '0;
    out_hit_y     <= m_found_r ? sat32(hy_sum) : '0;
    out_hit_param <= m_found_r ? m_param_r : '0;
  end

  property p_latency;
    @(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##(TOTAL_LAT) out_valid;
  endproperty
  a_latency: assert property (p_latency) else $error("result word missing");

  property p_miss_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && !out_found) |-> (out_hit_x == '0 && out_hit_y == '0 && out_hit_param == '0);
  endproperty
  a_miss_zero: assert property (p_miss_zero) else $error("miss word not cleared");

  property p_circle_back;
    @(posedge clk) disable iff (!rst_n)
      (p_vld_r && p_sb_r.found && p_sb_r.circ) |-> (p_param_r <= p_sb_r.t);
  endproperty
  a_circle_back: assert property (p_circle_back) else $error("circle parameter beyond t");

  property p_div_pair;
    @(posedge clk) disable iff (!rst_n) (div_vld == div_vld_u);
  endproperty
  a_div_pair: assert property (p_div_pair) else $error("divider words out of step");

endmodule

// File: verif/segment_line_circle_intersect_unit_tb.sv
module segment_line_circle_intersect_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slci_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int PIPE_LAT = 73;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] ax, ay, dax, day;
    logic [30:0]        len;
    logic signed [31:0] bx, by, dbx, dby;
    logic [30:0]        rad;
    bit                 drain;
  } query_t;

  typedef struct {
    logic               found;
    logic signed [31:0] hx, hy, prm;
  } hit_t;

  logic               clk, rst_n, start, busy;
  logic [1:0]         in_command;
  logic signed [31:0] in_seg_start_x, in_seg_start_y, in_seg_dir_x, in_seg_dir_y;
  logic [30:0]        in_seg_len;
  logic signed [31:0] in_other_x, in_other_y, in_other_dir_x, in_other_dir_y;
  logic [30:0]        in_other_len_or_radius;
  logic               out_valid, out_found;
  logic signed [31:0] out_hit_x, out_hit_y, out_hit_param;

  segment_line_circle_intersect_unit dut (.*);

  query_t pending_q[$];
  hit_t   hit_expect_q[$];
  query_t on_bus;
  int     gap_left, errors, n_sent, n_checked, n_found;
  int     per_cmd[4];
  bit     calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [127:0] cross2(logic signed [63:0] ax, logic signed [63:0] ay,
                                                 logic signed [63:0] bx, logic signed [63:0] by);
    logic signed [127:0] a, b, c, d;
    a = ax; b = ay; c = bx; d = by;
    return a * d - b * c;
  endfunction

  // Quotient of (num << FB) / den truncated toward zero, then clamped to 32 bits.
  function automatic logic signed [63:0] fx_quot(logic signed [127:0] num,
                                                 logic signed [127:0] den);
    logic [127:0] n, d, q;
    bit neg;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = (n << FB) / d;
    if (neg) return (q > 128'h8000_0000) ? -64'sd2147483648 : -$signed({1'b0, q[62:0]});
    return (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : $signed({1'b0, q[62:0]});
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic hit_t intersect_predict(query_t q);
    hit_t h;
    logic signed [63:0] ax, ay, dax, day, bx, by, dbx, dby, px, py, r, prm, t, u, g2;
    logic signed [127:0] den;
    ax = q.ax; ay = q.ay; dax = q.dax; day = q.day;
    bx = q.bx; by = q.by; dbx = q.dbx; dby = q.dby;
    r = {33'd0, q.rad};
    px = -day; py = dax;
    h = '{1'b0, 0, 0, 0};
    prm = 0;
    if (q.len != 0) begin
      if (q.cmd == CMD_SEG && q.rad != 0) begin
        den = cross2(dax, day, dbx, dby);
        if (den != 0) begin
          prm = fx_quot(cross2(bx - ax, by - ay, dbx, dby), den);
          h.found = 1;
        end
      end else if (q.cmd == CMD_NEAR) begin
        den = cross2(dax, day, px, py);
        if (den != 0) begin
          prm = fx_quot(cross2(bx - ax, by - ay, px, py), den);
          h.found = 1;
        end
      end else if (q.cmd == CMD_CIRCLE && q.rad != 0) begin
        den = cross2(dax, day, px, py);
        if (den != 0) begin
          t = fx_quot(cross2(bx - ax, by - ay, px, py), den);
          u = fx_quot(cross2(ax - bx, ay - by, dax, day), cross2(px, py, dax, day));
          g2 = r * r - u * u;
          if (g2 >= 0) begin
            prm = clamp32(t - $signed(floor_root(g2)));
            h.found = 1;
          end
        end
      end
    end
    if (h.found) begin
      // An arithmetic shift floors the scaled product, as the point needs.
      h.hx = 32'(clamp32(ax + ((dax * prm) >>> FB)));
      h.hy = 32'(clamp32(ay + ((day * prm) >>> FB)));
      h.prm = 32'(prm);
    end
    return h;
  endfunction

  task automatic report(string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(3, 1);
    return $urandom_range(120, 20);
  endfunction

  // Driver: a word stays on the bus until start meets a low busy.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        hit_expect_q.push_back(intersect_predict(on_bus));
        per_cmd[on_bus.cmd]++;
        n_sent++;
      end
      if (!start || !busy) begin
        if ($urandom_range(199) == 0) calm = !calm;
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() > 0 && !(pending_q[0].drain && hit_expect_q.size() > 0)) begin
          on_bus = pending_q.pop_front();
          in_command <= on_bus.cmd;
          in_seg_start_x <= on_bus.ax;
          in_seg_start_y <= on_bus.ay;
          in_seg_dir_x <= on_bus.dax;
          in_seg_dir_y <= on_bus.day;
          in_seg_len <= on_bus.len;
          in_other_x <= on_bus.bx;
          in_other_y <= on_bus.by;
          in_other_dir_x <= on_bus.dbx;
          in_other_dir_y <= on_bus.dby;
          in_other_len_or_radius <= on_bus.rad;
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_valid) begin
      if (hit_expect_q.size() == 0) begin
        report("result word with nothing outstanding");
      end else begin
        e = hit_expect_q.pop_front();
        n_checked++;
        if (e.found) n_found++;
        if (out_found !== e.found) report($sformatf("found %b exp %b", out_found, e.found));
        if (out_hit_x !== e.hx) report($sformatf("hit_x %h exp %h", out_hit_x, e.hx));
        if (out_hit_y !== e.hy) report($sformatf("hit_y %h exp %h", out_hit_y, e.hy));
        if (out_hit_param !== e.prm)
          report($sformatf("hit_param %h exp %h", out_hit_param, e.prm));
      end
    end
  end

  function automatic query_t mk(cmd_t c, int ax, int ay, int dax, int day, int len,
                                int bx, int by, int dbx, int dby, int rad);
    query_t q;
    q.cmd = c; q.ax = ax; q.ay = ay; q.dax = dax; q.day = day; q.len = 31'(len);
    q.bx = bx; q.by = by; q.dbx = dbx; q.dby = dby; q.rad = 31'(rad); q.drain = 0;
    return q;
  endfunction

  function automatic int near_val(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int k;
    k = $urandom_range(99);
    q.cmd = cmd_t'($urandom_range(7) == 0 ? 3 : $urandom_range(2));
    q.drain = 0;
    if (k < 30) begin
      q.ax = $urandom(); q.ay = $urandom(); q.dax = $urandom(); q.day = $urandom();
      q.bx = $urandom(); q.by = $urandom(); q.dbx = $urandom(); q.dby = $urandom();
      q.len = 31'($urandom()); q.rad = 31'($urandom());
    end else begin
      // Modest geometry so that circles are hit and points stay in range.
      q.ax = near_val(1 << 22); q.ay = near_val(1 << 22);
      q.dax = near_val(1 << 18); q.day = near_val(1 << 18);
      q.bx = near_val(1 << 22); q.by = near_val(1 << 22);
      q.dbx = near_val(1 << 18); q.dby = near_val(1 << 18);
      q.len = 31'($urandom_range(1 << 20, 1));
      q.rad = 31'($urandom_range(1 << 24, 1));
      if ($urandom_range(15) == 0) q.len = 0;
      if ($urandom_range(15) == 0) q.rad = 0;
      if ($urandom_range(15) == 0) begin
        q.dbx = q.dax * 2; q.dby = q.day * 2;
      end
    end
    return q;
  endfunction

  localparam int ONE = 1 << FB;

  initial begin
    query_t q;
    rst_n = 0; start = 0; calm = 0; errors = 0;
    in_command = 0; in_seg_start_x = 0; in_seg_start_y = 0; in_seg_dir_x = 0;
    in_seg_dir_y = 0; in_seg_len = 0; in_other_x = 0; in_other_y = 0;
    in_other_dir_x = 0; in_other_dir_y = 0; in_other_len_or_radius = 0;

    pending_q.push_back(mk(CMD_SEG, 0, 0, ONE, 0, ONE, ONE / 2, -ONE, 0, ONE, ONE));
    pending_q.push_back(mk(CMD_SEG, 0, 0, ONE, ONE, ONE, 5, 7, 2 * ONE, 2 * ONE, ONE));
    pending_q.push_back(mk(CMD_SEG, 0, 0, ONE, 0, 0, 0, -ONE, 0, ONE, ONE));
    pending_q.push_back(mk(CMD_SEG, 0, 0, ONE, 0, ONE, 0, -ONE, 0, ONE, 0));
    pending_q.push_back(mk(CMD_SEG, 0, 0, 0, 0, ONE, 0, -ONE, 0, ONE, ONE));
    pending_q.push_back(mk(CMD_SEG, -32'sh8000_0000, 32'sh7FFF_FFFF, 1, -1, 31'h7FFF_FFFF,
                           32'sh7FFF_FFFF, -32'sh8000_0000, 1, 1, 31'h7FFF_FFFF));
    pending_q.push_back(mk(CMD_NEAR, ONE, ONE, ONE, 0, ONE, 3 * ONE, 5 * ONE, 0, 0, 0));
    pending_q.push_back(mk(CMD_NEAR, 0, 0, 0, 0, ONE, ONE, ONE, 0, 0, ONE));
    pending_q.push_back(mk(CMD_NEAR, 0, 0, ONE, ONE, 0, ONE, ONE, 0, 0, ONE));
    pending_q.push_back(mk(CMD_NEAR, -32'sh8000_0000, -32'sh8000_0000, 32'sh7FFF_FFFF,
                           -32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           -1, -1, 31'h7FFF_FFFF));
    pending_q.push_back(mk(CMD_NEAR, 0, 0, 1, 0, ONE, 32'sh7FFF_FFFF, 0, 0, 0, 1));
    pending_q.push_back(mk(CMD_CIRCLE, -5 * ONE, 0, ONE, 0, ONE, 0, 0, 0, 0, 2 * ONE));
    pending_q.push_back(mk(CMD_CIRCLE, -5 * ONE, 0, ONE, 0, ONE, 0, 3 * ONE, 0, 0, 2 * ONE));
    pending_q.push_back(mk(CMD_CIRCLE, -5 * ONE, 0, ONE, 0, ONE, 0, 2 * ONE, 0, 0, 2 * ONE));
    pending_q.push_back(mk(CMD_CIRCLE, -5 * ONE, 0, ONE, 0, ONE, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(CMD_CIRCLE, -5 * ONE, 0, 0, 0, ONE, 0, 0, 0, 0, ONE));
    pending_q.push_back(mk(CMD_CIRCLE, -5 * ONE, 0, ONE, 0, 0, 0, 0, 0, 0, ONE));
    pending_q.push_back(mk(CMD_CIRCLE, 32'sh7FFF_FFFF, 0, 1, 0, 31'h7FFF_FFFF,
                           -32'sh8000_0000, 0, 0, 0, 31'h7FFF_FFFF));
    pending_q.push_back(mk(CMD_NONE, 0, 0, ONE, 0, ONE, ONE, -ONE, 0, ONE, ONE));
    pending_q.push_back(mk(CMD_NONE, -1, -1, -1, -1, 31'h7FFF_FFFF, -1, -1, -1, -1,
                           31'h7FFF_FFFF));
    for (int i = 0; i < 1300; i++) begin
      q = rand_query();
      // Now and then the sender holds until the pipeline has emptied.
      if (i % 400 == 200) q.drain = 1;
      pending_q.push_back(q);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1;
    while (pending_q.size() > 0 || start || hit_expect_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);

    $display("Checked %0d of %0d words: %0d seg, %0d nearest, %0d circle, %0d unused command.",
             n_checked, n_sent, per_cmd[0], per_cmd[1], per_cmd[2], per_cmd[3]);
    $display("Intersections found in %0d words; %0d mismatches.", n_found, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
